// File: hw/rtl/rsct_pkg.sv
`default_nettype none

package rsct_pkg;

   // coordinate and arithmetic widths; every stage is sized exactly
   localparam int COORD_BITS  = 16;
   localparam int STORE_BITS  = COORD_BITS + 1;
   localparam int AXIS_BITS   = STORE_BITS + 1;
   localparam int PROD_BITS   = STORE_BITS + AXIS_BITS;
   localparam int DOT_BITS    = PROD_BITS + 1;

   localparam int NUM_SLOTS   = 2;
   localparam int NUM_CORNERS = 4;
   localparam int NUM_AXES    = 4;

   // rectangle slots
   localparam logic SLOT_A = 1'b0;
   localparam logic SLOT_B = 1'b1;

   // corner codes
   localparam logic [1:0] CORNER_UL = 2'd0;
   localparam logic [1:0] CORNER_LL = 2'd1;
   localparam logic [1:0] CORNER_UR = 2'd2;
   localparam logic [1:0] CORNER_LR = 2'd3;

   // separating axis code when no axis separates
   localparam logic [2:0] AXIS_NONE = 3'd4;

   // axis k = slot[k] corner head[k] minus corner tail[k]
   //   0: A.UR - A.UL   1: A.UR - A.LR   2: B.UL - B.LL   3: B.UL - B.UR
   localparam logic [NUM_AXES-1:0] AXIS_SLOT = {SLOT_B, SLOT_B, SLOT_A, SLOT_A};
   localparam logic [2*NUM_AXES-1:0] AXIS_HEAD =
      {CORNER_UL, CORNER_UL, CORNER_UR, CORNER_UR};
   localparam logic [2*NUM_AXES-1:0] AXIS_TAIL =
      {CORNER_UR, CORNER_LL, CORNER_LR, CORNER_UL};

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [STORE_BITS-1:0] store_type;
   typedef logic signed [AXIS_BITS-1:0]  axis_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [DOT_BITS-1:0]   dot_type;

   typedef struct packed {
      logic      slot;
      coord_type pos_x;
      coord_type pos_y;
      coord_type ul_x;
      coord_type ul_y;
      coord_type ll_x;
      coord_type ll_y;
      coord_type ur_x;
      coord_type ur_y;
      coord_type lr_x;
      coord_type lr_y;
      logic      test_now;
   } req_type;

   typedef struct packed {
      logic       colliding;
      logic [2:0] separating_axis;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/rect_sat_collision_test_unit.sv
`default_nettype none

// Channel    Ports                        Direction  Handshake
// request    start, busy, req_data        in         accepted when start && !busy
// response   rsp_strobe, rsp_data         out        one cycle per strobe, no stall
//
// One request is taken every cycle while busy is low. A request with test_now set
// yields its response through the six-stage pipeline (store update, axes,
// products, dot sums, min/max, separation test).
// Synchronous reset clears the corner store and all valid bits; busy is high
// only while reset is asserted. The receiver cannot stall the response side.

module rect_sat_collision_test_unit
   import rsct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic accept;

   store_type off_x [NUM_CORNERS];
   store_type off_y [NUM_CORNERS];

   store_type store_x_ff [NUM_SLOTS][NUM_CORNERS];
   store_type store_y_ff [NUM_SLOTS][NUM_CORNERS];
   store_type store_x_in [NUM_SLOTS][NUM_CORNERS];
   store_type store_y_in [NUM_SLOTS][NUM_CORNERS];

   store_type snap_x_ff [NUM_SLOTS][NUM_CORNERS];
   store_type snap_y_ff [NUM_SLOTS][NUM_CORNERS];
   store_type crn_x_ff  [NUM_SLOTS][NUM_CORNERS];
   store_type crn_y_ff  [NUM_SLOTS][NUM_CORNERS];

   axis_type axis_x_ff [NUM_AXES];
   axis_type axis_y_ff [NUM_AXES];

   prod_type prod_x_ff [NUM_AXES][NUM_SLOTS][NUM_CORNERS];
   prod_type prod_y_ff [NUM_AXES][NUM_SLOTS][NUM_CORNERS];
   dot_type  dot_ff    [NUM_AXES][NUM_SLOTS][NUM_CORNERS];
   dot_type  lo_ff     [NUM_AXES][NUM_SLOTS];
   dot_type  hi_ff     [NUM_AXES][NUM_SLOTS];

   logic [NUM_AXES-1:0] sep;
   rsp_type             rsp_in;
   rsp_type             rsp_ff;

   logic snap_vld_ff;
   logic axis_vld_ff;
   logic prod_vld_ff;
   logic dot_vld_ff;
   logic range_vld_ff;
   logic rsp_strobe_ff;

   function automatic dot_type min2(dot_type a, dot_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic dot_type max2(dot_type a, dot_type b);
      return (a < b) ? b : a;
   endfunction

   assign busy   = reset;
   assign accept = start && !busy;

   // gather corner offsets in corner-code order
   always_comb begin
      off_x[CORNER_UL] = STORE_BITS'(req_data.ul_x);
      off_y[CORNER_UL] = STORE_BITS'(req_data.ul_y);
      off_x[CORNER_LL] = STORE_BITS'(req_data.ll_x);
      off_y[CORNER_LL] = STORE_BITS'(req_data.ll_y);
      off_x[CORNER_UR] = STORE_BITS'(req_data.ur_x);
      off_y[CORNER_UR] = STORE_BITS'(req_data.ur_y);
      off_x[CORNER_LR] = STORE_BITS'(req_data.lr_x);
      off_y[CORNER_LR] = STORE_BITS'(req_data.lr_y);
   end

   // merge the request's world corners into its slot
   always_comb begin
      store_x_in = store_x_ff;
      store_y_in = store_y_ff;
      if (accept) begin
         for (int c = 0; c < NUM_CORNERS; c++) begin
            store_x_in[req_data.slot][c] = STORE_BITS'(req_data.pos_x) + off_x[c];
            store_y_in[req_data.slot][c] = STORE_BITS'(req_data.pos_y) + off_y[c];
         end
      end
   end

   // hold the corner store; reset reads as the origin
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
               store_x_ff[s][c] <= '0;
               store_y_ff[s][c] <= '0;
            end
         end
      end else if (accept) begin
         store_x_ff <= store_x_in;
         store_y_ff <= store_y_in;
      end
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_vld_ff   <= 1'b0;
         axis_vld_ff   <= 1'b0;
         prod_vld_ff   <= 1'b0;
         dot_vld_ff    <= 1'b0;
         range_vld_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         snap_vld_ff   <= accept && req_data.test_now;
         axis_vld_ff   <= snap_vld_ff;
         prod_vld_ff   <= axis_vld_ff;
         dot_vld_ff    <= prod_vld_ff;
         range_vld_ff  <= dot_vld_ff;
         rsp_strobe_ff <= range_vld_ff;
      end
   end

   // stage 1: snapshot both rectangles as they stand after this request
   always_ff @(posedge clock) begin
      snap_x_ff <= store_x_in;
      snap_y_ff <= store_y_in;
   end

   // stage 2: form the edge axes 0 to 3, carry the corners along
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_AXES; k++) begin
         axis_x_ff[k] <=
            AXIS_BITS'(snap_x_ff[AXIS_SLOT[k]][AXIS_HEAD[2*k +: 2]]) -
            AXIS_BITS'(snap_x_ff[AXIS_SLOT[k]][AXIS_TAIL[2*k +: 2]]);
         axis_y_ff[k] <=
            AXIS_BITS'(snap_y_ff[AXIS_SLOT[k]][AXIS_HEAD[2*k +: 2]]) -
            AXIS_BITS'(snap_y_ff[AXIS_SLOT[k]][AXIS_TAIL[2*k +: 2]]);
      end
      crn_x_ff <= snap_x_ff;
      crn_y_ff <= snap_y_ff;
   end

   // stage 3: one product per corner coordinate and axis
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_AXES; k++) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
               prod_x_ff[k][s][c] <= PROD_BITS'(crn_x_ff[s][c]) * PROD_BITS'(axis_x_ff[k]);
               prod_y_ff[k][s][c] <= PROD_BITS'(crn_y_ff[s][c]) * PROD_BITS'(axis_y_ff[k]);
            end
         end
      end
   end

   // stage 4: finish the dot products
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_AXES; k++) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
               dot_ff[k][s][c] <= DOT_BITS'(prod_x_ff[k][s][c]) +
                                  DOT_BITS'(prod_y_ff[k][s][c]);
            end
         end
      end
   end

   // stage 5: projection range of each rectangle on each axis
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_AXES; k++) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            lo_ff[k][s] <= min2(min2(dot_ff[k][s][0], dot_ff[k][s][1]),
                                min2(dot_ff[k][s][2], dot_ff[k][s][3]));
            hi_ff[k][s] <= max2(max2(dot_ff[k][s][0], dot_ff[k][s][1]),
                                max2(dot_ff[k][s][2], dot_ff[k][s][3]));
         end
      end
   end

   // stage 6: touching ranges separate; report the first separating axis
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         sep[k] = (hi_ff[k][SLOT_A] <= lo_ff[k][SLOT_B]) ||
                  (hi_ff[k][SLOT_B] <= lo_ff[k][SLOT_A]);
      end
      rsp_in.colliding       = 1'b1;
      rsp_in.separating_axis = AXIS_NONE;
      for (int k = NUM_AXES - 1; k >= 0; k--) begin
         if (sep[k]) begin
            rsp_in.colliding       = 1'b0;
            rsp_in.separating_axis = 3'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a collision is reported exactly when no axis was found
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.colliding == (rsp_data.separating_axis == AXIS_NONE)))
      else $error("colliding flag disagrees with separating axis");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.separating_axis <= AXIS_NONE))
      else $error("separating axis code out of range");

   // every test request yields a response after the full pipeline
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.test_now) |-> ##6 rsp_strobe)
      else $error("test request produced no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && req_data.test_now, 6))
      else $error("response without a matching test request");

   assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("response strobe out of reset");

endmodule

`default_nettype wire

// File: tb/sv/rect_sat_collision_test_unit_tb.sv
`timescale 1ns / 100ps

module rect_sat_collision_test_unit_tb;
   import rsct_pkg::*;

   localparam int RANDOM_LOADS = 2000;
   localparam int QUIET_TAIL   = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      req_type data;
      int      gap;
      bit      drain;
   } rect_load_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // predicted world corners, [slot][corner][x/y]
   store_type     rect_corner [NUM_SLOTS][NUM_CORNERS][2] = '{default: '0};
   rsp_type       verdict_q [$];
   rect_load_type rect_load_q [$];
   rect_load_type staged;
   bit            staged_ok = 1'b0;
   bit            req_taken = 1'b0;
   rsp_type       want;
   int            loads_total = 0;
   int            loads_accepted = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   rect_sat_collision_test_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string msg);
      fail_count++;
      if (fail_count <= 100) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // store world corners: position plus each corner offset, exact at 17 bits
   function automatic void load_rect(req_type r);
      coord_type ox [NUM_CORNERS];
      coord_type oy [NUM_CORNERS];
      ox = '{r.ul_x, r.ll_x, r.ur_x, r.lr_x};
      oy = '{r.ul_y, r.ll_y, r.ur_y, r.lr_y};
      for (int c = 0; c < NUM_CORNERS; c++) begin
         rect_corner[r.slot][c][0] = store_type'(r.pos_x) + store_type'(ox[c]);
         rect_corner[r.slot][c][1] = store_type'(r.pos_y) + store_type'(oy[c]);
      end
   endfunction

   // separating axis test of A against B on the edge axes of both (0 and 1 from A, 2 and 3 from B)
   function automatic rsp_type sat_verdict();
      rsp_type    v;
      logic       s;
      logic [1:0] hd;
      logic [1:0] tl;
      axis_type   ax;
      axis_type   ay;
      dot_type    d;
      dot_type    lo [NUM_SLOTS];
      dot_type    hi [NUM_SLOTS];
      bit         found;
      v.colliding = 1'b1;
      v.separating_axis = AXIS_NONE;
      found = 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
         case (k)
            0: begin
               s = SLOT_A; hd = CORNER_UR; tl = CORNER_UL;
            end
            1: begin
               s = SLOT_A; hd = CORNER_UR; tl = CORNER_LR;
            end
            2: begin
               s = SLOT_B; hd = CORNER_UL; tl = CORNER_LL;
            end
            default: begin
               s = SLOT_B; hd = CORNER_UL; tl = CORNER_UR;
            end
         endcase
         ax = axis_type'(rect_corner[s][hd][0]) - axis_type'(rect_corner[s][tl][0]);
         ay = axis_type'(rect_corner[s][hd][1]) - axis_type'(rect_corner[s][tl][1]);
         for (int sl = 0; sl < NUM_SLOTS; sl++) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
               d = dot_type'(rect_corner[sl][c][0]) * dot_type'(ax)
                 + dot_type'(rect_corner[sl][c][1]) * dot_type'(ay);
               if (c == 0 || d < lo[sl]) lo[sl] = d;
               if (c == 0 || d > hi[sl]) hi[sl] = d;
            end
         end
         // touching ranges count as separated
         if (!found && (hi[0] <= lo[1] || hi[1] <= lo[0])) begin
            found = 1'b1;
            v.colliding = 1'b0;
            v.separating_axis = 3'(k);
         end
      end
      return v;
   endfunction

   // rectangle from center c and half vectors u, v
   function automatic req_type rect_req(logic slot, int cx, int cy, int ux, int uy,
                                        int vx, int vy, logic test);
      req_type r;
      r.slot     = slot;
      r.pos_x    = coord_type'(cx);
      r.pos_y    = coord_type'(cy);
      r.ul_x     = coord_type'(-ux + vx);
      r.ul_y     = coord_type'(-uy + vy);
      r.ll_x     = coord_type'(-ux - vx);
      r.ll_y     = coord_type'(-uy - vy);
      r.ur_x     = coord_type'(ux + vx);
      r.ur_y     = coord_type'(uy + vy);
      r.lr_x     = coord_type'(ux - vx);
      r.lr_y     = coord_type'(uy - vy);
      r.test_now = test;
      return r;
   endfunction

   // every position and offset field at one value
   function automatic req_type flat_req(logic slot, coord_type val, logic test);
      return '{slot, val, val, val, val, val, val, val, val, val, val, test};
   endfunction

   // random, roughly rectangular body; now and then skewed or collapsed
   function automatic req_type random_rect(logic slot, int cx, int cy, int span,
                                           logic test);
      int ux;
      int uy;
      int vx;
      int vy;
      int m;
      ux = int'($urandom_range(0, 2 * span)) - span;
      uy = int'($urandom_range(0, 2 * span)) - span;
      m  = int'($urandom_range(1, 8));
      vx = -uy * m / 4;
      vy = ux * m / 4;
      case ($urandom_range(0, 19))
         0, 1: begin
            vx += int'($urandom_range(0, 2 * span)) - span;
            vy += int'($urandom_range(0, 2 * span)) - span;
         end
         2: begin
            ux = 0; uy = 0;
         end
         default: ;
      endcase
      return rect_req(slot, cx, cy, ux, uy, vx, vy, test);
   endfunction

   function automatic int idle_burst(bit enabled);
      if (enabled && $urandom_range(0, 5) == 0) return int'($urandom_range(1, 13));
      return 0;
   endfunction

   task automatic queue_load(req_type r, int gap, bit drain);
      rect_load_type e;
      e.data  = r;
      e.gap   = gap;
      e.drain = drain;
      rect_load_q.insert(rect_load_q.size(), e);
      loads_total++;
   endtask

   // drive requests at the falling edge; advance once the current one is taken
   always @(negedge clock) begin
      if (!reset && (!start || req_taken)) begin
         if (!staged_ok && rect_load_q.size() != 0) begin
            staged = rect_load_q.pop_front();
            staged_ok = 1'b1;
         end
         if (!staged_ok) begin
            start <= 1'b0;
         end else if (staged.gap > 0) begin
            staged.gap = staged.gap - 1;
            start <= 1'b0;
         end else if (staged.drain && verdict_q.size() != 0) begin
            start <= 1'b0;
         end else begin
            req_data <= staged.data;
            start <= 1'b1;
            staged_ok = 1'b0;
         end
      end
   end

   // check responses, then predict for an accepted request
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.colliding !== want.colliding) begin
                  report_mismatch($sformatf("colliding got %b want %b",
                                            rsp_data.colliding, want.colliding));
               end
               if (rsp_data.separating_axis !== want.separating_axis) begin
                  report_mismatch($sformatf("separating_axis got %0d want %0d",
                                            rsp_data.separating_axis,
                                            want.separating_axis));
               end
            end
         end
         if (start && !busy) begin
            req_taken = 1'b1;
            loads_accepted++;
            load_rect(req_data);
            if (req_data.test_now) verdict_q.insert(verdict_q.size(), sat_verdict());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      req_type r;
      int      n;
      int      span;
      int      ax_c;
      int      ay_c;
      int      gap;
      bit      idle_on;
      bit      mid_drain;
      logic    first_slot;

      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;

      // directed: B never written reads as the origin, giving a zero-length axis
      queue_load(rect_req(SLOT_A, 0, 0, 16, 0, 0, 16, 1'b1), 0, 1'b0);
      // overlap, touching on x, touching on y
      queue_load(rect_req(SLOT_B, 8, 8, 16, 0, 0, 16, 1'b1), idle_burst(1'b1), 1'b0);
      queue_load(rect_req(SLOT_B, 32, 0, 16, 0, 0, 16, 1'b1), 0, 1'b0);
      queue_load(rect_req(SLOT_B, 0, 32, 16, 0, 0, 16, 1'b1), 0, 1'b0);
      // diamonds near a corner, separated only on an axis of B
      queue_load(rect_req(SLOT_B, 30, 30, 10, 10, -10, 10, 1'b1), 0, 1'b0);
      queue_load(rect_req(SLOT_B, -30, 30, 10, 10, -10, 10, 1'b1), 0, 1'b0);
      // loads without a test, then a test
      queue_load(rect_req(SLOT_B, 30, 30, 10, 10, -10, 10, 1'b0), 0, 1'b0);
      queue_load(rect_req(SLOT_A, 100, 100, 16, 0, 0, 16, 1'b0), idle_burst(1'b1), 1'b0);
      queue_load(rect_req(SLOT_B, 90, 90, 10, 10, -10, 10, 1'b1), 0, 1'b0);
      // B collapsed to a point inside A, then A collapsed
      queue_load(rect_req(SLOT_A, 0, 0, 16, 0, 0, 16, 1'b0), 0, 1'b0);
      queue_load(flat_req(SLOT_B, 16'sd0, 1'b1), 0, 1'b0);
      queue_load(flat_req(SLOT_A, 16'sd0, 1'b1), 0, 1'b0);
      // field extremes
      queue_load(flat_req(SLOT_A, 16'sh7FFF, 1'b0), 0, 1'b0);
      queue_load(flat_req(SLOT_B, 16'sh8000, 1'b1), 0, 1'b0);
      queue_load(flat_req(SLOT_A, 16'sh8000, 1'b1), 0, 1'b0);
      queue_load(flat_req(SLOT_B, 16'sh7FFF, 1'b1), 0, 1'b0);
      queue_load(rect_req(SLOT_A, 32767, 32767, 32767, 0, 0, 32767, 1'b0), 0, 1'b0);
      queue_load(rect_req(SLOT_B, -32768, -32768, 32767, 0, 0, 32767, 1'b1), 0, 1'b0);
      queue_load(rect_req(SLOT_B, 32767, -32768, 16384, 16383, -16383, 16384, 1'b1),
                 0, 1'b0);
      r = flat_req(SLOT_A, 16'sh5555, 1'b0);
      r.pos_y = 16'shAAAA;
      r.ll_x  = 16'shAAAA;
      r.lr_y  = 16'shAAAA;
      queue_load(r, 0, 1'b0);
      r = flat_req(SLOT_B, 16'shAAAA, 1'b1);
      r.pos_x = 16'sh5555;
      r.ur_y  = 16'sh5555;
      queue_load(r, 0, 1'b0);

      // random: mostly rectangle pairs near each other, some raw noise
      n = 0;
      mid_drain = 1'b0;
      while (n < RANDOM_LOADS) begin
         idle_on = (n < RANDOM_LOADS - QUIET_TAIL) && !(n >= 600 && n < 800);
         gap = idle_burst(idle_on);
         if ($urandom_range(0, 9) < 2) begin
            r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            queue_load(r, gap, n == 0);
            n++;
         end else begin
            span = ($urandom_range(0, 7) == 0) ? 4000 : int'($urandom_range(4, 400));
            ax_c = int'($urandom_range(0, 24000)) - 12000;
            ay_c = int'($urandom_range(0, 24000)) - 12000;
            first_slot = 1'($urandom_range(0, 1));
            queue_load(random_rect(first_slot, ax_c, ay_c, span,
                                   1'($urandom_range(0, 3) == 0)),
                       gap, n == 0 || (n >= 1000 && !mid_drain));
            if (n >= 1000) mid_drain = 1'b1;
            queue_load(random_rect(~first_slot,
                                   ax_c + int'($urandom_range(0, 6 * span)) - 3 * span,
                                   ay_c + int'($urandom_range(0, 6 * span)) - 3 * span,
                                   span, 1'b1),
                       idle_burst(idle_on), 1'b0);
            n += 2;
         end
      end

      // hold reset, then release it at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (loads_accepted == loads_total);
      wait (verdict_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
